// ===== rtl/tctd_pkg.sv =====
`timescale 1ns / 1ps

package tctd_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int RING_DEPTH  = 8;
	localparam int LIST_DEPTH  = 32;

	localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STACK_CW = $clog2(STACK_DEPTH + 1);
	localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LIST_AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int LIST_CW  = $clog2(LIST_DEPTH + 1);

	localparam int ID_W    = 16;
	localparam int PRIO_W  = 8;
	localparam int ENTRY_W = ID_W + PRIO_W;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [1:0]         code_t;

	localparam code_t MODE_PUSH_EMERGENCY = 2'd0;
	localparam code_t MODE_ENQ_PERIODIC   = 2'd1;
	localparam code_t MODE_INS_BACKGROUND = 2'd2;
	localparam code_t MODE_DISPATCH       = 2'd3;

	localparam code_t STATUS_DONE  = 2'd0;
	localparam code_t STATUS_FULL  = 2'd1;
	localparam code_t STATUS_EMPTY = 2'd2;

	localparam code_t CLASS_STACK = 2'd0;
	localparam code_t CLASS_RING  = 2'd1;
	localparam code_t CLASS_LIST  = 2'd2;

endpackage

// ===== rtl/three_class_task_dispatcher.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   mode, task_id, task_priority
// output    out        out_valid/out_stall status, task_valid, served_class, out_id, out_priority
//
// The store memories are read into the pending read stage in the cycle of acceptance,
// and the output register loads from that stage once the output side advances.
// One item is accepted every cycle while the output side keeps up.
// Reset clears all pointers and counts; store contents need no clearing pass.
// A stall on the output holds the output register and the pending read stage,
// which stalls the input once the pending read stage holds an item.

module three_class_task_dispatcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] task_id,
	input  logic [7:0]  task_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        task_valid,
	output logic [1:0]  served_class,
	output logic [15:0] out_id,
	output logic [7:0]  out_priority
);

	tctd_pkg::entry_t stack_mem [tctd_pkg::STACK_DEPTH];
	tctd_pkg::entry_t ring_mem  [tctd_pkg::RING_DEPTH];
	tctd_pkg::entry_t list_mem  [tctd_pkg::LIST_DEPTH];

	logic [tctd_pkg::STACK_CW-1:0] stack_count_q;
	logic [tctd_pkg::RING_AW-1:0]  ring_head_q;
	logic [tctd_pkg::RING_AW-1:0]  ring_tail_q;
	logic [tctd_pkg::LIST_AW-1:0]  list_pos_q;
	logic [tctd_pkg::LIST_CW-1:0]  list_count_q;

	logic                 s1_valid_q;
	tctd_pkg::code_t      status_s1;
	logic                 task_valid_s1;
	tctd_pkg::code_t      class_s1;
	tctd_pkg::entry_t     stack_rd_s1;
	tctd_pkg::entry_t     ring_rd_s1;
	tctd_pkg::entry_t     list_rd_s1;

	logic                 out_valid_q;
	tctd_pkg::code_t      status_q;
	logic                 task_valid_q;
	tctd_pkg::code_t      class_q;
	tctd_pkg::entry_t     out_entry_q;

	logic                 advance;
	logic                 accept;
	tctd_pkg::entry_t     in_entry;
	logic                 stack_full;
	logic                 stack_empty;
	logic                 ring_full;
	logic                 ring_empty;
	logic                 list_full;
	logic                 list_empty;
	logic [tctd_pkg::RING_AW-1:0]  ring_tail_next;
	logic [tctd_pkg::RING_AW-1:0]  ring_head_next;
	logic [tctd_pkg::LIST_AW-1:0]  list_pos_next;
	logic [tctd_pkg::LIST_AW:0]    list_sum;
	logic [tctd_pkg::LIST_AW-1:0]  list_wr_addr;
	logic [tctd_pkg::STACK_CW-1:0] stack_count_dec;
	logic [tctd_pkg::STACK_AW-1:0] stack_wr_addr;
	logic [tctd_pkg::STACK_AW-1:0] stack_rd_addr;
	logic                 stack_we;
	logic                 ring_we;
	logic                 list_we;
	logic                 stack_pop;
	logic                 ring_pop;
	logic                 list_pop;
	tctd_pkg::code_t      status_d;
	logic                 task_valid_d;
	tctd_pkg::code_t      class_d;
	tctd_pkg::entry_t     sel_entry;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;
	assign in_entry = {task_id, task_priority};

	assign stack_full  = (stack_count_q >= tctd_pkg::STACK_CW'(tctd_pkg::STACK_DEPTH));
	assign stack_empty = (stack_count_q == '0);
	assign ring_tail_next = (ring_tail_q == tctd_pkg::RING_AW'(tctd_pkg::RING_DEPTH - 1)) ?
		'0 : ring_tail_q + 1'b1;
	assign ring_head_next = (ring_head_q == tctd_pkg::RING_AW'(tctd_pkg::RING_DEPTH - 1)) ?
		'0 : ring_head_q + 1'b1;
	assign ring_full  = (ring_tail_next == ring_head_q);
	assign ring_empty = (ring_tail_q == ring_head_q);
	assign list_full  = (list_count_q >= tctd_pkg::LIST_CW'(tctd_pkg::LIST_DEPTH));
	assign list_empty = (list_count_q == '0);
	assign list_pos_next = (list_pos_q == tctd_pkg::LIST_AW'(tctd_pkg::LIST_DEPTH - 1)) ?
		'0 : list_pos_q + 1'b1;
	assign list_sum = {1'b0, list_pos_q} + (tctd_pkg::LIST_AW + 1)'(list_count_q);
	assign list_wr_addr = (list_sum >= (tctd_pkg::LIST_AW + 1)'(tctd_pkg::LIST_DEPTH)) ?
		tctd_pkg::LIST_AW'(list_sum - (tctd_pkg::LIST_AW + 1)'(tctd_pkg::LIST_DEPTH)) :
		list_sum[tctd_pkg::LIST_AW-1:0];
	assign stack_count_dec = stack_count_q - 1'b1;
	assign stack_wr_addr   = stack_count_q[tctd_pkg::STACK_AW-1:0];
	assign stack_rd_addr   = stack_count_dec[tctd_pkg::STACK_AW-1:0];

	always_comb begin
		stack_we     = 1'b0;
		ring_we      = 1'b0;
		list_we      = 1'b0;
		stack_pop    = 1'b0;
		ring_pop     = 1'b0;
		list_pop     = 1'b0;
		status_d     = tctd_pkg::STATUS_DONE;
		task_valid_d = 1'b0;
		class_d      = tctd_pkg::CLASS_STACK;
		case (mode)
			tctd_pkg::MODE_PUSH_EMERGENCY: begin
				if (stack_full) status_d = tctd_pkg::STATUS_FULL;
				else stack_we = 1'b1;
			end
			tctd_pkg::MODE_ENQ_PERIODIC: begin
				if (ring_full) status_d = tctd_pkg::STATUS_FULL;
				else ring_we = 1'b1;
			end
			tctd_pkg::MODE_INS_BACKGROUND: begin
				if (list_full) status_d = tctd_pkg::STATUS_FULL;
				else list_we = 1'b1;
			end
			default: begin
				if (!stack_empty) begin
					stack_pop    = 1'b1;
					task_valid_d = 1'b1;
					class_d      = tctd_pkg::CLASS_STACK;
				end else if (!ring_empty) begin
					ring_pop     = 1'b1;
					task_valid_d = 1'b1;
					class_d      = tctd_pkg::CLASS_RING;
				end else if (!list_empty) begin
					list_pop     = 1'b1;
					task_valid_d = 1'b1;
					class_d      = tctd_pkg::CLASS_LIST;
				end else begin
					status_d = tctd_pkg::STATUS_EMPTY;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && stack_we) stack_mem[stack_wr_addr] <= in_entry;
		if (accept && ring_we) ring_mem[ring_tail_q] <= in_entry;
		if (accept && list_we) list_mem[list_wr_addr] <= in_entry;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stack_rd_s1   <= stack_mem[stack_rd_addr];
			ring_rd_s1    <= ring_mem[ring_head_q];
			list_rd_s1    <= list_mem[list_pos_q];
			status_s1     <= status_d;
			task_valid_s1 <= task_valid_d;
			class_s1      <= class_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q <= '0;
			ring_head_q   <= '0;
			ring_tail_q   <= '0;
			list_pos_q    <= '0;
			list_count_q  <= '0;
		end else if (accept) begin
			if (stack_we) stack_count_q <= stack_count_q + 1'b1;
			if (stack_pop) stack_count_q <= stack_count_dec;
			if (ring_we) ring_tail_q <= ring_tail_next;
			if (ring_pop) ring_head_q <= ring_head_next;
			if (list_we) list_count_q <= list_count_q + 1'b1;
			if (list_pop) begin
				list_count_q <= list_count_q - 1'b1;
				list_pos_q   <= list_pos_next;
			end
		end
	end

	always_comb begin
		case (class_s1)
			tctd_pkg::CLASS_STACK: sel_entry = stack_rd_s1;
			tctd_pkg::CLASS_RING:  sel_entry = ring_rd_s1;
			default:               sel_entry = list_rd_s1;
		endcase
		if (!task_valid_s1) sel_entry = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= s1_valid_q;
				s1_valid_q  <= accept;
			end else if (accept) begin
				s1_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			status_q     <= status_s1;
			task_valid_q <= task_valid_s1;
			class_q      <= class_s1;
			out_entry_q  <= sel_entry;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign task_valid   = task_valid_q;
	assign served_class = task_valid_q ? class_q : tctd_pkg::CLASS_STACK;
	assign out_id       = out_entry_q[tctd_pkg::ENTRY_W-1:tctd_pkg::PRIO_W];
	assign out_priority = out_entry_q[tctd_pkg::PRIO_W-1:0];

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= tctd_pkg::STACK_CW'(tctd_pkg::STACK_DEPTH))
		else $error("stack count above depth");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		list_count_q <= tctd_pkg::LIST_CW'(tctd_pkg::LIST_DEPTH))
		else $error("list count above depth");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && task_valid) |-> (status == tctd_pkg::STATUS_DONE))
		else $error("dispatched task with non-done status");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !task_valid) |-> (out_id == '0 && out_priority == '0))
		else $error("nonzero task fields without a task");

endmodule

// ===== verif/three_class_task_dispatcher_test.sv =====
`timescale 1ns / 1ps

module three_class_task_dispatcher_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		tctd_pkg::code_t status;
		logic            task_valid;
		tctd_pkg::code_t served_class;
		logic [15:0]     id;
		logic [7:0]      prio;
	} reply_t;

	class dispatch_scoreboard;
		tctd_pkg::entry_t stack_mem[tctd_pkg::STACK_DEPTH];
		tctd_pkg::entry_t ring_mem[tctd_pkg::RING_DEPTH];
		tctd_pkg::entry_t list_mem[tctd_pkg::LIST_DEPTH];
		int     stack_fill;
		int     ring_rd;
		int     ring_wr;
		int     list_rd;
		int     list_fill;
		reply_t pending[$];
		int     errors;

		function void note_request(tctd_pkg::code_t m, logic [15:0] id, logic [7:0] prio);
			reply_t           r;
			tctd_pkg::entry_t e;
			int               nxt;
			r = '0;
			r.status = tctd_pkg::STATUS_DONE;
			e = {id, prio};
			case (m)
				tctd_pkg::MODE_PUSH_EMERGENCY: begin
					if (stack_fill >= tctd_pkg::STACK_DEPTH) begin
						r.status = tctd_pkg::STATUS_FULL;
					end else begin
						stack_mem[stack_fill] = e;
						stack_fill++;
					end
				end
				tctd_pkg::MODE_ENQ_PERIODIC: begin
					nxt = (ring_wr + 1) % tctd_pkg::RING_DEPTH;
					if (nxt == ring_rd) begin
						r.status = tctd_pkg::STATUS_FULL;
					end else begin
						ring_mem[ring_wr] = e;
						ring_wr = nxt;
					end
				end
				tctd_pkg::MODE_INS_BACKGROUND: begin
					if (list_fill >= tctd_pkg::LIST_DEPTH) begin
						r.status = tctd_pkg::STATUS_FULL;
					end else begin
						list_mem[(list_rd + list_fill) % tctd_pkg::LIST_DEPTH] = e;
						list_fill++;
					end
				end
				default: begin
					if (stack_fill > 0) begin
						stack_fill--;
						r.task_valid = 1'b1;
						r.served_class = tctd_pkg::CLASS_STACK;
						{r.id, r.prio} = stack_mem[stack_fill];
					end else if (ring_rd != ring_wr) begin
						r.task_valid = 1'b1;
						r.served_class = tctd_pkg::CLASS_RING;
						{r.id, r.prio} = ring_mem[ring_rd];
						ring_rd = (ring_rd + 1) % tctd_pkg::RING_DEPTH;
					end else if (list_fill > 0) begin
						r.task_valid = 1'b1;
						r.served_class = tctd_pkg::CLASS_LIST;
						{r.id, r.prio} = list_mem[list_rd];
						list_rd = (list_rd + 1) % tctd_pkg::LIST_DEPTH;
						list_fill--;
					end else begin
						r.status = tctd_pkg::STATUS_EMPTY;
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				$error("Output transfer arrived with no expected result waiting.");
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("task_valid", want.task_valid, got.task_valid);
			compare_field("served_class", want.served_class, got.served_class);
			compare_field("out_id", want.id, got.id);
			compare_field("out_priority", want.prio, got.prio);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = 2'd0;
	logic [15:0] task_id = 16'd0;
	logic [7:0]  task_priority = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        task_valid;
	logic [1:0]  served_class;
	logic [15:0] out_id;
	logic [7:0]  out_priority;

	dispatch_scoreboard board = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int cycle_count = 0;

	three_class_task_dispatcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.task_id      (task_id),
		.task_priority(task_priority),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.task_valid   (task_valid),
		.served_class (served_class),
		.out_id       (out_id),
		.out_priority (out_priority)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver either stalls at random or, on request, holds off for a long stretch.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			board.check_reply({status, task_valid, served_class, out_id, out_priority});
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_request(tctd_pkg::code_t m, logic [15:0] id, logic [7:0] prio);
		in_valid <= 1'b1;
		mode <= m;
		task_id <= id;
		task_priority <= prio;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(m, id, prio);
	endtask

	task automatic send_gapped(tctd_pkg::code_t m, logic [15:0] id, logic [7:0] prio);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		send_request(m, id, prio);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Segments either flood one store, lean toward inserts, or lean toward dispatch,
	// so that every store reaches both full and empty and the pointers wrap.
	task automatic run_random(int count);
		int              left;
		int              kind;
		int              seg_len;
		int              target;
		int              roll;
		tctd_pkg::code_t m;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(2);
			seg_len = $urandom_range(10, 50);
			target = $urandom_range(2);
			for (int k = 0; k < seg_len && left > 0; k++) begin
				roll = $urandom_range(99);
				case (kind)
					0: m = (roll < 90) ? tctd_pkg::code_t'(target) : tctd_pkg::MODE_DISPATCH;
					1: m = (roll < 70) ? tctd_pkg::code_t'($urandom_range(2)) :
						tctd_pkg::MODE_DISPATCH;
					default: m = (roll < 75) ? tctd_pkg::MODE_DISPATCH :
						tctd_pkg::code_t'($urandom_range(2));
				endcase
				send_gapped(m, 16'($urandom), 8'($urandom));
				left--;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct <= 32;
		rx_idle_pct <= 80;
		@(posedge clk);

		send_gapped(tctd_pkg::MODE_DISPATCH, 16'hFFFF, 8'hFF);
		send_gapped(tctd_pkg::MODE_PUSH_EMERGENCY, 16'hFFFF, 8'hFF);
		send_gapped(tctd_pkg::MODE_PUSH_EMERGENCY, 16'h0000, 8'h00);
		send_gapped(tctd_pkg::MODE_ENQ_PERIODIC, 16'hFFFF, 8'h00);
		send_gapped(tctd_pkg::MODE_ENQ_PERIODIC, 16'h0000, 8'hFF);
		send_gapped(tctd_pkg::MODE_INS_BACKGROUND, 16'hAAAA, 8'h55);
		send_gapped(tctd_pkg::MODE_INS_BACKGROUND, 16'h5555, 8'hAA);
		repeat (7) send_gapped(tctd_pkg::MODE_DISPATCH, 16'($urandom), 8'($urandom));
		run_random(150);
		wait_drained();

		// The receiver holds off while items keep coming, so the input must stall.
		tx_idle_pct <= 0;
		hold_asked <= hold_asked + 1;
		run_random(20);
		wait_drained();

		tx_idle_pct <= 80;
		rx_idle_pct <= 32;
		run_random(180);
		wait_drained();

		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		run_random(200);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending.size() != 0) begin
			$error("%0d expected results never arrived.", board.pending.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
